@@ rtl/mtl_pkg.sv @@
// package: token kinds, lexer modes, result and step types
`default_nettype none

package mtl_pkg;

    localparam logic [1:0] KIND_SPECIAL = 2'd0;
    localparam logic [1:0] KIND_STRING  = 2'd1;
    localparam logic [1:0] KIND_SYMBOL  = 2'd2;

    localparam logic [7:0] LIMIT_RESET = 8'd254;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_STR  = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_SYM  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [1:0] token_kind;
        logic       has_char;
        logic [7:0] out_char;
        logic       token_end;
    } result_t;

    typedef struct packed {
        logic [1:0] n_results;
        result_t    r0;
        result_t    r1;
        mode_t      mode;
        logic [7:0] count;
    } step_t;

endpackage

`default_nettype wire

@@ rtl/mtl_in_if.sv @@
// interfaces: input byte channel, result channel, configuration write channel
`default_nettype none

interface mtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface mtl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] token_kind;
    logic       has_char;
    logic [7:0] out_char;
    logic       token_end;
    modport source (output valid, output token_kind, output has_char, output out_char,
                    output token_end, input ready);
    modport sink   (input valid, input token_kind, input has_char, input out_char,
                    input token_end, output ready);
endinterface

interface mtl_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_limit;
    modport source (output valid, output symbol_limit, input ready);
    modport sink   (input valid, input symbol_limit, output ready);
endinterface

`default_nettype wire

@@ rtl/mtl_step.sv @@
// lexer step: next mode, symbol count and up to two results for one byte
`default_nettype none

module mtl_step
    import mtl_pkg::*;
(
    input  wire mode_t      mode,
    input  wire logic [7:0] count,
    input  wire logic [7:0] limit,
    input  wire logic [7:0] c,
    output step_t           step
);

    logic       is_white;
    logic       is_special;
    logic [7:0] lim;
    logic [8:0] cnt_wide;
    logic [7:0] cnt;
    logic       cut;
    result_t    sym_res;
    result_t    spc_res;
    result_t    str_end;

    always_comb
    begin
        is_white   = (c != CH_NUL) && (c <= CH_SPACE);
        is_special = (c == CH_LT) || (c == CH_GT) || (c == CH_SLASH) ||
                     (c == CH_EQ) || (c == CH_QMARK);
        lim        = (limit == 8'd0) ? 8'd1 : limit;
        cnt_wide   = {1'b0, ((mode == MODE_SYM) ? count : 8'd0)} + 9'd1;
        cnt        = cnt_wide[8] ? 8'hff : cnt_wide[7:0];
        cut        = (cnt >= lim);
        sym_res    = '{token_kind: KIND_SYMBOL, has_char: 1'b1, out_char: c, token_end: cut};
        spc_res    = '{token_kind: KIND_SPECIAL, has_char: 1'b1, out_char: c, token_end: 1'b1};
        str_end    = '{token_kind: KIND_STRING, has_char: 1'b0, out_char: 8'd0,
                       token_end: 1'b1};

        step.n_results = 2'd0;
        step.r0        = '0;
        step.r1        = '0;
        step.mode      = mode;
        step.count     = count;

        case (mode)
            MODE_IDLE:
            begin
                if ((c == CH_NUL) || is_white)
                begin
                    step.n_results = 2'd0;
                end
                else if (is_special)
                begin
                    step.n_results = 2'd1;
                    step.r0        = spc_res;
                end
                else if (c == CH_QUOTE)
                begin
                    step.mode = MODE_STR;
                end
                else
                begin
                    step.n_results = 2'd1;
                    step.r0        = sym_res;
                    step.mode      = cut ? MODE_IDLE : MODE_SYM;
                    step.count     = cut ? 8'd0 : cnt;
                end
            end
            MODE_STR:
            begin
                if ((c == CH_NUL) || (c == CH_QUOTE))
                begin
                    step.n_results = 2'd1;
                    step.r0        = str_end;
                    step.mode      = MODE_IDLE;
                end
                else if (c == CH_BSLASH)
                begin
                    step.mode = MODE_ESC;
                end
                else
                begin
                    step.n_results = 2'd1;
                    step.r0        = '{token_kind: KIND_STRING, has_char: 1'b1, out_char: c,
                                       token_end: 1'b0};
                end
            end
            MODE_ESC:
            begin
                if (c == CH_NUL)
                begin
                    step.n_results = 2'd1;
                    step.r0        = str_end;
                    step.mode      = MODE_IDLE;
                end
                else
                begin
                    step.mode = MODE_STR;
                    step.r0   = '{token_kind: KIND_STRING, has_char: 1'b1, out_char: CH_BSLASH,
                                  token_end: 1'b0};
                    if (c == CH_N)
                    begin
                        step.n_results   = 2'd1;
                        step.r0.out_char = CH_LF;
                    end
                    else if (c == CH_T)
                    begin
                        step.n_results   = 2'd1;
                        step.r0.out_char = CH_TAB;
                    end
                    else if (c == CH_R)
                    begin
                        step.n_results   = 2'd1;
                        step.r0.out_char = CH_CR;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        step.n_results = 2'd1;
                    end
                end
            end
            MODE_SYM:
            begin
                if ((c == CH_NUL) || is_white || is_special)
                begin
                    step.n_results = is_special ? 2'd2 : 2'd1;
                    step.r0        = '{token_kind: KIND_SYMBOL, has_char: 1'b0, out_char: 8'd0,
                                       token_end: 1'b1};
                    step.r1        = spc_res;
                    step.mode      = MODE_IDLE;
                    step.count     = 8'd0;
                end
                else
                begin
                    step.n_results = 2'd1;
                    step.r0        = sym_res;
                    step.mode      = cut ? MODE_IDLE : MODE_SYM;
                    step.count     = cut ? 8'd0 : cnt;
                end
            end
            default:
            begin
                step.mode  = MODE_IDLE;
                step.count = 8'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/markup_token_lexer_unit.sv @@
// top level: markup token lexer with result queue and configuration register
//
// usage
// - stream: one input byte per item, accepted when valid and ready are high
// - tokens: one result per item (kind, has_char, out_char, token_end)
// - cfg: writes symbol_limit, always ready; write only while the block is idle
// - each byte updates the lexer state in the cycle it is accepted and pushes
//   zero, one or two results into a four-entry result queue
// - results of a byte are registered in the queue when the byte is accepted
// - throughput: one byte per cycle while each byte gives at most one result;
//   and the receiver is ready; a byte that ends a symbol at a special
//   character gives two results, and the queue drains one result per cycle
// - stream.ready is high while the queue has at least two free entries
// - when the receiver stalls, results wait in the queue in order and
//   stream.ready falls once the queue is nearly full; nothing is lost
// - reset: between tokens, symbol count zero, symbol_limit 254, queue empty
`default_nettype none

module markup_token_lexer_unit
    import mtl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mtl_in_if.sink     stream,
    mtl_out_if.source  tokens,
    mtl_cfg_if.sink    cfg
);

    mode_t            mode_reg;
    logic [7:0]       count_reg;
    logic [7:0]       limit_reg;
    result_t          queue_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     fill_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QAW:0]     fill_next;
    step_t            step;
    logic             accept;
    logic             pop;
    logic [1:0]       push_n;
    result_t          head;

    mtl_step u_step (
        .mode  (mode_reg),
        .count (count_reg),
        .limit (limit_reg),
        .c     (stream.in_byte),
        .step  (step)
    );

    assign stream.ready = (fill_reg <= (QAW+1)'(QDEPTH - 2));
    assign cfg.ready    = 1'b1;
    assign accept       = stream.valid && stream.ready;
    assign pop          = tokens.valid && tokens.ready;
    assign push_n       = accept ? step.n_results : 2'd0;

    assign head              = queue_reg[rd_ptr_reg];
    assign tokens.valid      = (fill_reg != '0);
    assign tokens.token_kind = head.token_kind;
    assign tokens.has_char   = head.has_char;
    assign tokens.out_char   = head.out_char;
    assign tokens.token_end  = head.token_end;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push_n);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        fill_next   = fill_reg + (QAW+1)'(push_n) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            count_reg  <= 8'd0;
            limit_reg  <= LIMIT_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= step.mode;
                count_reg <= step.count;
            end
            if (cfg.valid)
            begin
                limit_reg <= cfg.symbol_limit;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= step.r0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QAW'(1)] <= step.r1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mtl_checker.sv @@
// checker: port-level properties of the lexer result channel, bound to the top level
`default_nettype none

module mtl_checker
    import mtl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] token_kind,
    input wire logic       has_char,
    input wire logic [7:0] out_char,
    input wire logic       token_end
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
        $stable(has_char) && $stable(out_char) && $stable(token_end))
        else $error("stalled result changed");

    a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> token_end && (out_char == 8'd0) &&
        (token_kind != KIND_SPECIAL))
        else $error("bad end marker");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (token_kind == KIND_SPECIAL) || (token_kind == KIND_STRING) ||
        (token_kind == KIND_SYMBOL))
        else $error("illegal token kind");

    a_string_char_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_char && (token_kind == KIND_STRING) |-> !token_end)
        else $error("string character marked as last");

    a_special_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == KIND_SPECIAL) |-> has_char && token_end)
        else $error("special token not a single character");

endmodule

bind markup_token_lexer_unit mtl_checker u_mtl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (tokens.valid),
    .out_ready  (tokens.ready),
    .token_kind (tokens.token_kind),
    .has_char   (tokens.has_char),
    .out_char   (tokens.out_char),
    .token_end  (tokens.token_end)
);

`default_nettype wire
